// File: rtl/sirdig_pkg.sv
// sirdig_pkg: widths, character codes, register indexes and status types
// shared by the signed integer to radix digits block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sirdig_pkg;

  localparam int VAL_W        = 32;
  localparam int CHAR_W       = 8;
  localparam int LEN_W        = 5;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;
  localparam int ALPH_BYTES   = 16;
  localparam int MAX_BASE_DEF = 16;
  localparam int MAX_DIGITS   = 32;
  localparam int DIG_IDX_W    = 5;
  localparam int DIG_CNT_W    = 6;
  localparam int DIV_STEP     = 4;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

  localparam logic [1:0] REG_BASE_LEN  = 2'd0;
  localparam logic [1:0] REG_ALPH_LOW  = 2'd1;
  localparam logic [1:0] REG_ALPH_HIGH = 2'd2;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_stat_t;

endpackage

`default_nettype wire

// File: rtl/sirdig_achk.sv
// sirdig_achk: alphabet check, one row a cycle: digit a against the sign
// characters and against every later digit in use. Depends on sirdig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirdig_achk #(
  parameter int MAX_BASE = sirdig_pkg::MAX_BASE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   go,
  input  logic [sirdig_pkg::LEN_W-1:0]           len,
  input  logic [MAX_BASE-1:0][sirdig_pkg::CHAR_W-1:0] alph,
  output sirdig_pkg::chk_stat_t                  stat
);
  import sirdig_pkg::*;

  localparam int DIG_W = $clog2(MAX_BASE);

  logic [DIG_W-1:0]  row_r;
  logic              running_r;
  logic              done_r;
  logic              ok_r;
  logic [CHAR_W-1:0] row_char;
  logic              row_bad;
  logic              last_row;

  always_comb begin
    row_char = alph[row_r];
    row_bad  = (row_char == PLUS_CHAR) || (row_char == MINUS_CHAR);
    for (int b = 0; b < MAX_BASE; b++) begin
      if ((LEN_W'(b) < len) && (DIG_W'(b) > row_r) && (alph[b] == row_char)) begin
        row_bad = 1'b1;
      end
    end
    last_row = ({{(LEN_W-DIG_W){1'b0}}, row_r} == (len - LEN_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      ok_r      <= 1'b0;
      row_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        running_r <= 1'b1;
        row_r     <= '0;
      end else if (running_r) begin
        if (row_bad) begin
          done_r    <= 1'b1;
          ok_r      <= 1'b0;
          running_r <= 1'b0;
        end else if (last_row) begin
          done_r    <= 1'b1;
          ok_r      <= 1'b1;
          running_r <= 1'b0;
        end else begin
          row_r <= row_r + DIG_W'(1);
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.ok   = ok_r;

endmodule

`default_nettype wire

// File: rtl/sirdig_div.sv
// sirdig_div: restoring divider, 32-bit dividend by the radix, four
// quotient bits a cycle. Depends on sirdig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirdig_div #(
  parameter int MAX_BASE = sirdig_pkg::MAX_BASE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 go,
  input  logic [sirdig_pkg::VAL_W-1:0]         dividend,
  input  logic [$clog2(2*MAX_BASE)-1:0]        divisor,
  output logic                                 done,
  output logic [sirdig_pkg::VAL_W-1:0]         quotient,
  output logic [$clog2(MAX_BASE)-1:0]          remainder
);
  import sirdig_pkg::*;

  localparam int REM_W = $clog2(2*MAX_BASE);
  localparam int DIG_W = $clog2(MAX_BASE);
  localparam int NCYC  = VAL_W / DIV_STEP;
  localparam int CNT_W = $clog2(NCYC);

  logic [VAL_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0] r_r, r_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             running_r;
  logic             done_r;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      r_nxt = {r_nxt[REM_W-2:0], q_nxt[VAL_W-1]};
      q_nxt = {q_nxt[VAL_W-2:0], 1'b0};
      if (r_nxt >= divisor) begin
        r_nxt    = r_nxt - divisor;
        q_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NCYC - 1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (running_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r[DIG_W-1:0];

endmodule

`default_nettype wire

// File: rtl/signed_int_to_radix_digits.sv
// signed_int_to_radix_digits: top level, register file, sequencer and digit
// stack. Depends on sirdig_pkg, sirdig_achk and sirdig_div.
//
//   channel  ports                                    handshake
//   input    in_value                                 start & !busy
//   result   out_character, out_last                  out_strobe, one cycle
//   config   psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// An item runs up to base_length rows of alphabet check, then one divider pass
// per digit (the four-bit-a-cycle loop), then puts out one character a cycle.
// A bad alphabet gives no beat; busy then stays low, or drops after the check.
// Reset is synchronous: registers read 0 and the sequencer idles.
// Result beats cannot be stalled; busy stays high until the last one.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_radix_digits #(
  parameter int MAX_BASE = sirdig_pkg::MAX_BASE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sirdig_pkg::VAL_W-1:0]   in_value,
  output logic                                  out_strobe,
  output logic [sirdig_pkg::CHAR_W-1:0]         out_character,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sirdig_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sirdig_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sirdig_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                  pready
);
  import sirdig_pkg::*;

  localparam int DIG_W = $clog2(MAX_BASE);
  localparam int REM_W = $clog2(2*MAX_BASE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] alow_r;
  logic [CFG_DATA_W-1:0] ahigh_r;

  logic [2:0]            state_r;
  logic                  neg_r;
  logic [VAL_W-1:0]      mag_r;
  logic                  div_go_r;
  logic [DIG_CNT_W-1:0]  nd_r;
  logic [DIG_CNT_W-1:0]  nd_m1;
  logic [DIG_W-1:0]      stack_r [MAX_DIGITS];

  logic                  out_strobe_r;
  logic [CHAR_W-1:0]     out_character_r;
  logic                  out_last_r;

  logic [MAX_BASE-1:0][CHAR_W-1:0] alph;
  logic [2*CFG_DATA_W-1:0]         alph_all;
  logic                  cfg_wr;
  logic                  accept;
  logic                  len_ok;
  chk_stat_t             chk_stat;
  logic                  div_done;
  logic [VAL_W-1:0]      div_q;
  logic [DIG_W-1:0]      div_rem;

  assign alph_all = {ahigh_r, alow_r};
  always_comb begin
    for (int k = 0; k < MAX_BASE; k++) begin
      alph[k] = alph_all[8*k +: 8];
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      alow_r  <= '0;
      ahigh_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_BASE_LEN:  len_r   <= pwdata[LEN_W-1:0];
        REG_ALPH_LOW:  alow_r  <= pwdata;
        REG_ALPH_HIGH: ahigh_r <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_BASE_LEN:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, len_r};
      REG_ALPH_LOW:  prdata = alow_r;
      REG_ALPH_HIGH: prdata = ahigh_r;
      default:       prdata = '0;
    endcase
  end

  // sequencer
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign len_ok = (len_r >= LEN_W'(2)) && (len_r <= LEN_W'(MAX_BASE));
  assign nd_m1  = nd_r - DIG_CNT_W'(1);

  sirdig_achk #(.MAX_BASE(MAX_BASE)) u_achk (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (accept && len_ok),
    .len   (len_r),
    .alph  (alph),
    .stat  (chk_stat)
  );

  sirdig_div #(.MAX_BASE(MAX_BASE)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go_r),
    .dividend  (mag_r),
    .divisor   (len_r[REM_W-1:0]),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_go_r     <= 1'b0;
      nd_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      div_go_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && len_ok) begin
            state_r <= S_CHECK;
            nd_r    <= '0;
          end
        end
        S_CHECK: begin
          if (chk_stat.done) begin
            if (chk_stat.ok) begin
              state_r  <= S_DIV;
              div_go_r <= 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            nd_r <= nd_r + DIG_CNT_W'(1);
            if (div_q != '0) begin
              div_go_r <= 1'b1;
            end else if (neg_r) begin
              state_r <= S_SIGN;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SIGN: begin
          out_strobe_r <= 1'b1;
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          out_strobe_r <= 1'b1;
          nd_r         <= nd_m1;
          if (nd_r == DIG_CNT_W'(1)) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload: magnitude, digit stack, result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= in_value[VAL_W-1];
      mag_r <= in_value[VAL_W-1] ? (VAL_W'(~in_value) + VAL_W'(1)) : VAL_W'(in_value);
    end else if ((state_r == S_DIV) && div_done) begin
      mag_r <= div_q;
    end
    if ((state_r == S_DIV) && div_done) begin
      stack_r[nd_r[DIG_IDX_W-1:0]] <= div_rem;
    end
    if (state_r == S_SIGN) begin
      out_character_r <= MINUS_CHAR;
      out_last_r      <= 1'b0;
    end else if (state_r == S_EMIT) begin
      out_character_r <= alph[stack_r[nd_m1[DIG_IDX_W-1:0]]];
      out_last_r      <= (nd_r == DIG_CNT_W'(1));
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  a_beat_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without an item in flight");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("sequencer still busy after last beat");

  a_bad_len_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !len_ok) |=> !busy)
    else $error("item taken with an invalid base length");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= DIG_CNT_W'(MAX_DIGITS))
    else $error("digit stack overflow");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (nd_r != '0))
    else $error("emitting from an empty digit stack");

endmodule

`default_nettype wire

// File: test/tb_signed_int_to_radix_digits.sv
// Self-checking testbench for signed_int_to_radix_digits: signed values are
// rendered as radix text against an in-bench predictor, under fixed and random configs.
// Depends on sirdig_pkg and the signed_int_to_radix_digits RTL.
`timescale 1ns / 1ps

module tb_signed_int_to_radix_digits;
  import sirdig_pkg::*;

  localparam int RADIX_MAX    = MAX_BASE_DEF;
  localparam int DRAIN_CYCLES = 400;
  localparam int LIMIT_CYCLES = 600000;
  localparam int RAND_STRETCH = 40;

  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  // "76543210" and "fedcba98", digit 0 in the low byte
  localparam logic [63:0] DEC_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] DEC_HIGH = 64'h6665_6463_6261_3938;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } char_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VAL_W-1:0]      in_value = '0;
  logic                  out_strobe;
  logic [CHAR_W-1:0]     out_character;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [LEN_W-1:0] mdl_len = '0;
  logic [63:0]      mdl_low = '0;
  logic [63:0]      mdl_high = '0;

  char_beat_t pending_chars[$];
  char_beat_t want;
  int         mismatches = 0;
  int         cycles = 0;
  int         sender_idle_pct = 25;

  signed_int_to_radix_digits #(.MAX_BASE(RADIX_MAX)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_character(out_character),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               pending_chars.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] digit_glyph(input int k);
    if (k < 8) return mdl_low[8*k +: 8];
    if (k < 16) return mdl_high[8*(k-8) +: 8];
    return '0;
  endfunction

  function automatic bit alphabet_valid();
    logic [CHAR_W-1:0] ca;
    if (mdl_len < 2 || mdl_len > RADIX_MAX) return 1'b0;
    for (int a = 0; a < mdl_len; a++) begin
      ca = digit_glyph(a);
      if (ca == PLUS_CHAR || ca == MINUS_CHAR) return 1'b0;
      for (int b = a + 1; b < mdl_len; b++)
        if (digit_glyph(b) == ca) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic [VAL_W-1:0] raw);
    logic             neg;
    logic [VAL_W:0]   mag;
    logic [LEN_W-1:0] digs [MAX_DIGITS];
    int               nd;
    neg = raw[VAL_W-1];
    mag = neg ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
    nd = 0;
    if (!alphabet_valid()) return;
    do begin
      digs[nd] = LEN_W'(mag % mdl_len);
      nd++;
      mag = mag / mdl_len;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (neg) pending_chars.push_back('{glyph: MINUS_CHAR, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      pending_chars.push_back('{glyph: digit_glyph(digs[i]), last: (i == 0)});
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat at %0t: char %02h last %0b", $realtime,
                   out_character, out_last);
      end else begin
        want = pending_chars.pop_front();
        if (out_character !== want.glyph || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected char %02h last %0b, got char %02h last %0b",
                     $realtime, want.glyph, want.last, out_character, out_last);
        end
      end
    end
  end

  task automatic send_item(input logic [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    predict_text(v);
  endtask

  // all beats in, block idle, then allow for a silent check pass
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_chars.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] reg_idx, input logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (reg_idx)
      REG_BASE_LEN:  mdl_len = data[LEN_W-1:0];
      REG_ALPH_LOW:  mdl_low = data;
      REG_ALPH_HIGH: mdl_high = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [LEN_W-1:0] len, input logic [63:0] lo,
                           input logic [63:0] hi);
    logic [CFG_DATA_W-1:0] len_word;
    wait_quiet();
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len;
    apb_write(REG_BASE_LEN, len_word);
    apb_write(REG_ALPH_LOW, lo);
    apb_write(REG_ALPH_HIGH, hi);
  endtask

  task automatic test_decimal();
    configure(5'd10, DEC_LOW, DEC_HIGH);
    send_item(32'd0);
    send_item(32'd7);
    send_item(-32'sd7);
    send_item(INT_MAX);
    send_item(INT_MIN);
    send_item(32'd1000);
    send_item(32'hFFFF_FFFF);
  endtask

  task automatic test_radix_limits();
    configure(5'd2, DEC_LOW, DEC_HIGH);
    send_item(INT_MIN);
    send_item(INT_MAX);
    send_item(32'd0);
    // zero byte and top-bit bytes are plain digits
    configure(5'd16, 64'h0706_0504_0302_FF00, 64'h8079_7877_7675_7473);
    send_item(32'd0);
    send_item(32'hFFFF_FFFF);
    send_item(INT_MAX);
    // sign characters beyond the used length do not count
    configure(5'd3, 64'h2D2B_2D2B_2D63_6261, 64'h2B2D_2B2D_2B2D_2B2D);
    send_item(-32'sd5);
  endtask

  task automatic test_bad_alphabet();
    configure(5'd0, DEC_LOW, DEC_HIGH);
    send_item(32'd12);
    configure(5'd1, DEC_LOW, DEC_HIGH);
    send_item(-32'sd12);
    configure(5'd17, DEC_LOW, DEC_HIGH);
    send_item(INT_MAX);
    configure(5'd31, DEC_LOW, DEC_HIGH);
    send_item(INT_MIN);
    configure(5'd10, 64'h3736_3534_2B32_3130, DEC_HIGH);
    send_item(32'd99);
    configure(5'd16, DEC_LOW, 64'h2D65_6463_6261_3938);
    send_item(32'd99);
    configure(5'd12, DEC_LOW, 64'h6665_6463_3561_3938);
    send_item(32'd99);
    // unmapped register index leaves the alphabet untouched
    configure(5'd10, DEC_LOW, DEC_HIGH);
    apb_write(REG_SPARE, {$urandom, $urandom});
    send_item(32'd42);
    send_item(-32'sd42);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 40) - 32'd20;
      7: begin
        case ($urandom_range(0, 5))
          0: return INT_MIN;
          1: return INT_MAX;
          2: return 32'd0;
          3: return 32'hFFFF_FFFF;
          4: return 32'd1;
          default: return INT_MIN + 32'd1;
        endcase
      end
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic pick_alphabet(output logic [LEN_W-1:0] len, output logic [63:0] lo,
                               output logic [63:0] hi);
    logic [CHAR_W-1:0] glyph [ALPH_BYTES];
    bit   [255:0]      taken;
    int                mode;
    int                i;
    int                j;
    logic [CHAR_W-1:0] b;
    mode = $urandom_range(0, 19);
    case (mode)
      0: len = $urandom_range(0, 1);
      1: len = $urandom_range(RADIX_MAX + 1, 31);
      default: len = $urandom_range(2, RADIX_MAX);
    endcase
    taken = '0;
    for (i = 0; i < ALPH_BYTES; i++) begin
      if (i < len) begin
        do b = $urandom; while (b == PLUS_CHAR || b == MINUS_CHAR || taken[b]);
        taken[b] = 1'b1;
        glyph[i] = b;
      end else begin
        glyph[i] = $urandom;
      end
    end
    if (mode == 2) begin
      glyph[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? PLUS_CHAR : MINUS_CHAR;
    end else if (mode == 3) begin
      i = $urandom_range(0, len - 2);
      j = $urandom_range(i + 1, len - 1);
      glyph[j] = glyph[i];
    end
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = glyph[i];
      hi[8*i +: 8] = glyph[i+8];
    end
  endtask

  task automatic test_random();
    int               pcts [3];
    int               sent;
    int               chunk;
    logic [LEN_W-1:0] len;
    logic [63:0]      lo;
    logic [63:0]      hi;
    pcts = '{25, 52, 0};
    foreach (pcts[p]) begin
      sender_idle_pct = pcts[p];
      sent = 0;
      while (sent < RAND_STRETCH) begin
        pick_alphabet(len, lo, hi);
        configure(len, lo, hi);
        chunk = $urandom_range(4, 12);
        repeat (chunk) send_item(rand_value());
        sent += chunk;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_decimal();
    test_radix_limits();
    test_bad_alphabet();
    test_random();
    wait_quiet();
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
